@@ rtl/core/i2c_master_transaction_engine_defines.svh @@
// Assertion macros shared by the engine modules
`ifndef I2C_MASTER_TRANSACTION_ENGINE_DEFINES_SVH
`define I2C_MASTER_TRANSACTION_ENGINE_DEFINES_SVH

// Implication checked on every clock edge outside reset
`define I2CM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("i2cm assertion failed");

// Next-cycle implication checked outside reset
`define I2CM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("i2cm assertion failed");

`endif

@@ rtl/core/i2cm_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants of the I2C master transaction engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int unsigned MaxBytes = 16;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_START = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  localparam logic [1:0] CFG_CLK_WAIT  = 2'd0;
  localparam logic [1:0] CFG_DATA_WAIT = 2'd1;
  localparam logic [1:0] CFG_ATTEMPTS  = 2'd2;
  localparam logic [1:0] CFG_HALF_PER  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NACK    = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;

  // one queued item
  typedef struct packed {
    action_e    action;
    logic [3:0] load_index;
    logic [7:0] write_byte;
    logic [6:0] device_address;
    logic       read_not_write;
    logic [4:0] byte_count;
    logic       scl_in;
    logic       sda_in;
  } item_t;

  // one result
  typedef struct packed {
    logic       scl_drive;
    logic       scl_level;
    logic       sda_drive;
    logic       sda_level;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic [4:0] bytes_done;
  } result_t;

endpackage

@@ rtl/core/i2cm_item_fifo.sv @@
// ----------------------------------------------------------------------------
// i2cm_item_fifo
// Front end: accepts input transactions, passes unused actions on as no-op
// items and queues them for the bus sequencer in a two-entry queue.
// ----------------------------------------------------------------------------
module i2cm_item_fifo import i2cm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  item_t in_item_i,
  output logic  out_valid_o,
  input  logic  out_pop_i,
  output item_t out_item_o
);
  `include "i2c_master_transaction_engine_defines.svh"

  item_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  item_t      item_c;

  // the unused action code passes through as an explicit no-op item
  always_comb begin
    item_c = in_item_i;
    if (in_item_i.action == ACT_NONE) item_c.action = ACT_NONE;
  end

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o && out_pop_i;
  assign out_item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= item_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  `I2CM_ASSERT_IMP(a_no_over, cnt_q == 2'd2, !push)
  `I2CM_ASSERT_IMP(a_cnt_max, 1'b1, cnt_q != 2'd3)
  `I2CM_ASSERT_NXT(a_cnt_inc, push && !pop, cnt_q == $past(cnt_q) + 2'd1)
endmodule

@@ rtl/core/i2cm_sequencer.sv @@
// ----------------------------------------------------------------------------
// i2cm_sequencer
// Back end: runs the bus sequencer for one queued item per cycle while the
// output is not stalled and places the result in an output register.
// ----------------------------------------------------------------------------
module i2cm_sequencer import i2cm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        item_valid_i,
  output logic        item_pop_o,
  input  item_t       item_i,
  input  logic [17:0] clk_wait_i,
  input  logic [17:0] data_wait_i,
  input  logic [2:0]  attempts_i,
  input  logic [15:0] half_per_i,
  output logic        res_valid_o,
  input  logic        res_stall_i,
  output result_t     res_o
);
  `include "i2c_master_transaction_engine_defines.svh"

  localparam logic [4:0] PH_IDLE = 5'd0, PH_START_A = 5'd1, PH_START_B = 5'd2,
    PH_TX_WCLK = 5'd3, PH_TX_LOW = 5'd4, PH_TX_WDAT = 5'd5, PH_TX_BLO = 5'd6,
    PH_TX_BHI = 5'd7, PH_ACK_LO = 5'd8, PH_ACK_HI = 5'd9, PH_FIN_WCLK = 5'd10,
    PH_RX_WCLK = 5'd11, PH_RX_BLO = 5'd12, PH_RX_WCLK2 = 5'd13, PH_RX_BHI = 5'd14,
    PH_MACK_A = 5'd15, PH_MACK_B = 5'd16, PH_MACK_C = 5'd17, PH_STOP_A = 5'd18,
    PH_STOP_B = 5'd19, PH_STOP_C = 5'd20, PH_STOP_D = 5'd21;

  logic [7:0]  wbuf_q [MaxBytes];
  logic [4:0]  phase_q, phase_d;
  logic [3:0]  bit_q, bit_d;
  logic [4:0]  idx_q, idx_d;
  logic [7:0]  sh_q, sh_d;
  logic [17:0] wait_q, wait_d;
  logic [15:0] dly_q, dly_d;
  logic [2:0]  att_q, att_d;
  logic        aack_q, aack_d, astg_q, astg_d;
  logic [6:0]  addr_q, addr_d;
  logic        dir_q, dir_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [1:0]  st_q, st_d;
  logic        lsd_q, lsl_q;
  logic        res_valid_q;
  result_t     res_q, res_c;
  logic        adv, dd, lvl;
  logic [15:0] dly_inc, hp;
  logic [17:0] wlim, wait_inc;
  logic [7:0]  wbyte;
  logic        valid_c, done_c;

  assign adv         = item_valid_i && (!res_valid_q || !res_stall_i);
  assign item_pop_o  = adv;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign hp          = (half_per_i == 16'd0) ? 16'd1 : half_per_i;
  assign dly_inc     = dly_q + 16'd1;
  assign wait_inc    = wait_q + 18'd1;
  assign wbyte       = wbuf_q[idx_q[3:0]];

  // write buffer
  always_ff @(posedge clk_i) begin
    if (adv && item_i.action == ACT_LOAD) wbuf_q[item_i.load_index] <= item_i.write_byte;
  end

  // next state
  always_comb begin
    phase_d = phase_q; bit_d = bit_q; idx_d = idx_q; sh_d = sh_q;
    wait_d = wait_q; dly_d = dly_q; att_d = att_q; aack_d = aack_q;
    astg_d = astg_q; addr_d = addr_q; dir_d = dir_q; cnt_d = cnt_q;
    st_d = st_q; valid_c = 1'b0; done_c = 1'b0;
    dd = 1'b0; lvl = 1'b0; wlim = 18'd1;

    unique case (item_i.action)
      ACT_START: begin
        if (phase_q == PH_IDLE) begin
          addr_d = item_i.device_address;
          dir_d  = item_i.read_not_write;
          cnt_d  = (item_i.byte_count > 5'(MaxBytes)) ? 5'(MaxBytes) : item_i.byte_count;
          att_d = 3'd0; aack_d = 1'b0; idx_d = 5'd0; st_d = ST_OK;
          phase_d = PH_START_A; dly_d = 16'd0; wait_d = 18'd0;
        end
      end
      ACT_TICK: begin
        // half-period delay step
        if (dly_inc >= hp) begin
          dd = 1'b1; dly_d = 16'd0;
        end else begin
          dly_d = dly_inc;
        end
        unique case (phase_q)
          PH_TX_WCLK, PH_FIN_WCLK, PH_RX_WCLK, PH_RX_WCLK2: begin
            lvl = item_i.scl_in; wlim = clk_wait_i;
          end
          PH_TX_WDAT: begin
            lvl = item_i.sda_in; wlim = data_wait_i;
          end
          default: ;
        endcase
        if (wlim == 18'd0) wlim = 18'd1;

        unique case (phase_q)
          PH_TX_WCLK, PH_FIN_WCLK, PH_RX_WCLK, PH_RX_WCLK2, PH_TX_WDAT: begin
            if (lvl) begin
              dly_d = 16'd0; wait_d = 18'd0;
              unique case (phase_q)
                PH_TX_WCLK:  phase_d = PH_TX_LOW;
                PH_TX_WDAT:  phase_d = PH_TX_BLO;
                PH_FIN_WCLK: phase_d = PH_STOP_A;
                PH_RX_WCLK:  phase_d = PH_RX_BLO;
                default:     phase_d = PH_RX_BHI;
              endcase
            end else if (dd) begin
              wait_d = wait_inc;
              if (wait_inc >= wlim) begin
                st_d = ST_TIMEOUT; phase_d = PH_STOP_A; wait_d = 18'd0;
              end
            end
          end
          PH_START_A: if (dd) begin phase_d = PH_START_B; wait_d = 18'd0; end
          PH_START_B: if (dd) begin
            sh_d = {addr_q, dir_q}; bit_d = 4'd0; astg_d = 1'b1;
            phase_d = PH_TX_WCLK; wait_d = 18'd0;
          end
          PH_TX_LOW:  if (dd) begin phase_d = PH_TX_WDAT; wait_d = 18'd0; end
          PH_TX_BLO:  if (dd) begin phase_d = PH_TX_BHI; wait_d = 18'd0; end
          PH_TX_BHI: if (dd) begin
            bit_d = bit_q + 4'd1; wait_d = 18'd0;
            phase_d = (bit_q + 4'd1 >= 4'd8) ? PH_ACK_LO : PH_TX_BLO;
          end
          PH_ACK_LO: if (dd) begin phase_d = PH_ACK_HI; wait_d = 18'd0; end
          PH_ACK_HI: if (dd) begin
            wait_d = 18'd0;
            if (item_i.sda_in) begin
              st_d = ST_NACK; phase_d = PH_STOP_A;
            end else if (astg_q && dir_q) begin
              aack_d = 1'b1;
              if (idx_q < cnt_q) begin
                bit_d = 4'd0; sh_d = 8'd0; phase_d = PH_RX_WCLK;
              end else begin
                phase_d = PH_STOP_A;
              end
            end else begin
              if (astg_q) aack_d = 1'b1;
              else        idx_d  = idx_q + 5'd1;
              // next write byte or final clock wait
              if (astg_q ? (idx_q < cnt_q) : (idx_q + 5'd1 < cnt_q)) begin
                sh_d = astg_q ? wbyte : wbuf_q[4'(idx_q + 5'd1)];
                bit_d = 4'd0; astg_d = 1'b0; phase_d = PH_TX_WCLK;
              end else begin
                phase_d = PH_FIN_WCLK;
              end
            end
          end
          PH_RX_BLO: if (dd) begin
            phase_d = (bit_q == 4'd0) ? PH_RX_WCLK2 : PH_RX_BHI; wait_d = 18'd0;
          end
          PH_RX_BHI: if (dd) begin
            sh_d = {sh_q[6:0], item_i.sda_in}; bit_d = bit_q + 4'd1; wait_d = 18'd0;
            if (bit_q + 4'd1 >= 4'd8) begin
              valid_c = 1'b1; idx_d = idx_q + 5'd1; phase_d = PH_MACK_A;
            end else begin
              phase_d = PH_RX_BLO;
            end
          end
          PH_MACK_A: if (dd) begin phase_d = PH_MACK_B; wait_d = 18'd0; end
          PH_MACK_B: if (dd) begin phase_d = PH_MACK_C; wait_d = 18'd0; end
          PH_MACK_C: if (dd) begin
            wait_d = 18'd0;
            if (idx_q < cnt_q) begin
              bit_d = 4'd0; sh_d = 8'd0; phase_d = PH_RX_WCLK;
            end else begin
              phase_d = PH_STOP_A;
            end
          end
          PH_STOP_A: if (dd) begin phase_d = PH_STOP_B; wait_d = 18'd0; end
          PH_STOP_B: if (dd) begin phase_d = PH_STOP_C; wait_d = 18'd0; end
          PH_STOP_C: if (dd) begin phase_d = PH_STOP_D; wait_d = 18'd0; end
          PH_STOP_D: if (dd) begin
            wait_d = 18'd0;
            if (st_q != ST_OK && aack_q && ({1'b0, att_q} + 4'd1 < {1'b0, attempts_i})) begin
              att_d = att_q + 3'd1; idx_d = 5'd0; st_d = ST_OK; phase_d = PH_START_A;
            end else begin
              done_c = 1'b1; phase_d = PH_IDLE;
            end
          end
          default: begin
            phase_d = PH_IDLE; dly_d = 16'd0; wait_d = 18'd0;
          end
        endcase
      end
      default: ;
    endcase
  end

  // pin outputs from the new phase
  always_comb begin
    res_c = '0;
    unique case (phase_d)
      PH_START_A: begin
        res_c.scl_drive = 1'b1; res_c.scl_level = 1'b1;
        res_c.sda_drive = 1'b1; res_c.sda_level = 1'b1;
      end
      PH_START_B: begin
        res_c.scl_drive = 1'b1; res_c.scl_level = 1'b1; res_c.sda_drive = 1'b1;
      end
      PH_TX_WCLK, PH_FIN_WCLK, PH_RX_WCLK: res_c.sda_drive = 1'b1;
      PH_TX_LOW: begin res_c.scl_drive = 1'b1; res_c.sda_drive = 1'b1; end
      PH_TX_WDAT: res_c.scl_drive = 1'b1;
      PH_TX_BLO, PH_TX_BHI: begin
        res_c.scl_drive = 1'b1; res_c.scl_level = (phase_d == PH_TX_BHI);
        res_c.sda_drive = 1'b1; res_c.sda_level = sh_d[3'd7 - bit_d[2:0]];
      end
      PH_ACK_LO, PH_RX_BLO: res_c.scl_drive = 1'b1;
      PH_ACK_HI, PH_RX_BHI: begin res_c.scl_drive = 1'b1; res_c.scl_level = 1'b1; end
      PH_MACK_A: begin res_c.scl_drive = 1'b1; res_c.sda_drive = 1'b1; end
      PH_MACK_B, PH_MACK_C: begin
        res_c.scl_drive = 1'b1; res_c.scl_level = (phase_d == PH_MACK_C);
        res_c.sda_drive = 1'b1; res_c.sda_level = (idx_d >= cnt_d);
      end
      PH_STOP_A: begin
        res_c.scl_drive = 1'b1; res_c.sda_drive = lsd_q; res_c.sda_level = lsl_q;
      end
      PH_STOP_B: begin res_c.scl_drive = 1'b1; res_c.sda_drive = 1'b1; end
      PH_STOP_C: begin
        res_c.scl_drive = 1'b1; res_c.scl_level = 1'b1; res_c.sda_drive = 1'b1;
      end
      PH_STOP_D: begin
        res_c.scl_drive = 1'b1; res_c.scl_level = 1'b1;
        res_c.sda_drive = 1'b1; res_c.sda_level = 1'b1;
      end
      default: ;
    endcase
    res_c.read_byte  = valid_c ? sh_d : 8'd0;
    res_c.read_valid = valid_c;
    res_c.busy_res   = (phase_d != PH_IDLE);
    res_c.done_res   = done_c;
    res_c.status     = st_d;
    res_c.bytes_done = idx_d;
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (adv) res_q <= res_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; bit_q <= '0; idx_q <= '0; sh_q <= '0; wait_q <= '0;
      dly_q <= '0; att_q <= '0; aack_q <= 1'b0; astg_q <= 1'b0; addr_q <= '0;
      dir_q <= 1'b0; cnt_q <= '0; st_q <= ST_OK; lsd_q <= 1'b0; lsl_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        phase_q <= phase_d; bit_q <= bit_d; idx_q <= idx_d; sh_q <= sh_d;
        wait_q <= wait_d; dly_q <= dly_d; att_q <= att_d; aack_q <= aack_d;
        astg_q <= astg_d; addr_q <= addr_d; dir_q <= dir_d; cnt_q <= cnt_d;
        st_q <= st_d; lsd_q <= res_c.sda_drive; lsl_q <= res_c.sda_level;
        res_valid_q <= 1'b1;
      end else if (!res_stall_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  `I2CM_ASSERT_IMP(a_cnt_sat, 1'b1, cnt_q <= 5'(MaxBytes))
  `I2CM_ASSERT_IMP(a_idx_le, phase_q != PH_IDLE, idx_q <= cnt_q)
  `I2CM_ASSERT_NXT(a_hold, res_valid_q && res_stall_i, res_valid_q && $stable(res_q))
endmodule

@@ rtl/core/i2c_master_transaction_engine.sv @@
// ----------------------------------------------------------------------------
// i2c_master_transaction_engine
// I2C master running complete 7-bit address write or read transactions.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid_i / in_stall_o) carries one item per
// transaction: a tick with sampled scl_in_i / sda_in_i, a write buffer load,
// or a transaction start. Each accepted item gives exactly one result on the
// output channel (out_valid_o / out_stall_i) with pin controls, read data
// and status. Configuration is written on cfg_valid_i / cfg_ready_o with
// cfg_index_i selecting clock wait, data wait, attempt limit or half period.
// Path: an accepted item is written into the queue, and the sequencer then
// places its result in the output register; an output stall holds it back.
// Throughput: one item per cycle while the output is not stalled.
// A two-entry queue sits in front, so the input is stalled only when the
// queue fills while the output is stalled.
// Reset clears the sequencer to idle and the registers to their defaults;
// the write buffer is undefined until loaded. While out_stall_i is high the
// result holds and the queue absorbs up to two further items.
// ----------------------------------------------------------------------------
module i2c_master_transaction_engine import i2cm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [3:0]  load_index_i,
  input  logic [7:0]  write_byte_i,
  input  logic [6:0]  device_address_i,
  input  logic        read_not_write_i,
  input  logic [4:0]  byte_count_i,
  input  logic        scl_in_i,
  input  logic        sda_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        scl_drive_o,
  output logic        scl_level_o,
  output logic        sda_drive_o,
  output logic        sda_level_o,
  output logic [7:0]  read_byte_o,
  output logic        read_valid_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic [1:0]  status_o,
  output logic [4:0]  bytes_done_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [17:0] cfg_data_i
);
  logic [17:0] clk_wait_q, data_wait_q;
  logic [2:0]  attempts_q;
  logic [15:0] half_per_q;
  item_t       in_item, q_item;
  logic        q_valid, q_pop;
  result_t     res;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_wait_q  <= 18'd200000;
      data_wait_q <= 18'd100000;
      attempts_q  <= 3'd3;
      half_per_q  <= 16'd1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_CLK_WAIT:  clk_wait_q  <= cfg_data_i;
        CFG_DATA_WAIT: data_wait_q <= cfg_data_i;
        CFG_ATTEMPTS:  attempts_q  <= cfg_data_i[2:0];
        CFG_HALF_PER:  half_per_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_item.action         = action_e'(action_i);
    in_item.load_index     = load_index_i;
    in_item.write_byte     = write_byte_i;
    in_item.device_address = device_address_i;
    in_item.read_not_write = read_not_write_i;
    in_item.byte_count     = byte_count_i;
    in_item.scl_in         = scl_in_i;
    in_item.sda_in         = sda_in_i;
  end

  i2cm_item_fifo u_fifo (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .in_item_i(in_item),
    .out_valid_o(q_valid), .out_pop_i(q_pop), .out_item_o(q_item)
  );

  i2cm_sequencer u_seq (
    .clk_i, .rst_ni,
    .item_valid_i(q_valid), .item_pop_o(q_pop), .item_i(q_item),
    .clk_wait_i(clk_wait_q), .data_wait_i(data_wait_q),
    .attempts_i(attempts_q), .half_per_i(half_per_q),
    .res_valid_o(out_valid_o), .res_stall_i(out_stall_i), .res_o(res)
  );

  assign scl_drive_o  = res.scl_drive;
  assign scl_level_o  = res.scl_level;
  assign sda_drive_o  = res.sda_drive;
  assign sda_level_o  = res.sda_level;
  assign read_byte_o  = res.read_byte;
  assign read_valid_o = res.read_valid;
  assign busy_res_o   = res.busy_res;
  assign done_res_o   = res.done_res;
  assign status_o     = res.status;
  assign bytes_done_o = res.bytes_done;
endmodule
